[src/upc_pkg.sv]
// Package with the shared types, character constants and byte classifiers of the URL codec.
package upc_pkg;

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [3:0] DigitTen  = 4'd10;

  localparam int unsigned PktBytes = 3;
  localparam int unsigned QDepth   = 2;

  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendPct   = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  typedef struct packed {
    logic [PktBytes-1:0][7:0] bytes;
    logic [1:0]               count;
    logic                     last;
  } pkt_t;

  function automatic logic is_hex(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     8'h2D, 8'h5F, 8'h2E, 8'h7E};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - CharZero;
    end else if (b inside {[8'h61:8'h66]}) begin
      v = b - CharLowA + {4'd0, DigitTen};
    end else begin
      v = b - CharUpA + {4'd0, DigitTen};
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DigitTen) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = CharUpA + {4'd0, d - DigitTen};
    end
    return c;
  endfunction

endpackage

[src/url_percent_codec_top.sv]
// Top level of the streaming URL percent encoder and decoder.
// Input items are bytes with a last flag on the final byte of each string; an
// item is taken at a clock edge where in_valid_i is high and in_stall_o is low.
// Output items are bytes with a last flag, taken where out_valid_o is high and
// out_stall_i is low. cfg_we_i writes cfg_decode_mode_i (0 encodes, 1 decodes)
// and drops any partial escape; write it only while the block is idle.
// The front end takes one byte per cycle unless in_stall_o is high, and turns it
// into a packet of zero to three output bytes; non-empty packets enter a
// two-entry packet queue. The back end sends one output byte per cycle from the
// queue through an output register while out_stall_i is low. An accepted byte
// passes through the queue and then the output register. Input throughput is
// one byte per cycle while each byte yields at most one output byte and
// out_stall_i is low; a three-byte escape holds the input while the back end sends it.
// When the receiver stalls, the output register holds its item, the queue fills
// and in_stall_o rises. Reset clears the mode to encode, the pending escape
// state and the queue; no item is lost or repeated across a stall.
module url_percent_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_decode_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  upc_pkg::pkt_t pkt, head;
  logic          push, full, q_valid, pop, in_fire;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  upc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_decode_mode_i (cfg_decode_mode_i),
    .in_fire_i         (in_fire),
    .in_byte_i         (in_byte_i),
    .in_last_i         (in_last_i),
    .push_o            (push),
    .pkt_o             (pkt)
  );

  upc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (pkt),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  upc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

[src/upc_front.sv]
// Front end: accepts input items, tracks pending escapes and builds output packets.
module upc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_decode_mode_i,
  input  logic          in_fire_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          push_o,
  output upc_pkg::pkt_t pkt_o
);

  logic       mode_q;
  logic [1:0] pend_q, pend_d;
  logic [7:0] held_q, held_d;

  logic       fresh_emit;
  logic [7:0] fresh_byte;
  logic [1:0] fresh_pend;
  logic [1:0] pre_cnt;

  always_comb begin
    fresh_emit = 1'b1;
    fresh_byte = in_byte_i;
    fresh_pend = upc_pkg::PendNone;
    if (in_byte_i == upc_pkg::CharPct) begin
      if (!in_last_i) begin
        fresh_emit = 1'b0;
        fresh_pend = upc_pkg::PendPct;
      end
    end else if (in_byte_i == upc_pkg::CharPlus) begin
      fresh_byte = upc_pkg::CharSpace;
    end
  end

  always_comb begin
    pkt_o      = '0;
    pkt_o.last = in_last_i;
    pend_d     = pend_q;
    held_d     = held_q;
    pre_cnt    = 2'd0;
    if (!mode_q) begin
      if (upc_pkg::is_plain(in_byte_i)) begin
        pkt_o.bytes[0] = in_byte_i;
        pkt_o.count    = 2'd1;
      end else begin
        pkt_o.bytes[0] = upc_pkg::CharPct;
        pkt_o.bytes[1] = upc_pkg::hex_char(in_byte_i[7:4]);
        pkt_o.bytes[2] = upc_pkg::hex_char(in_byte_i[3:0]);
        pkt_o.count    = 2'd3;
      end
    end else if (pend_q == upc_pkg::PendDigit && upc_pkg::is_hex(in_byte_i)) begin
      pkt_o.bytes[0] = {upc_pkg::hex_val(held_q), upc_pkg::hex_val(in_byte_i)};
      pkt_o.count    = 2'd1;
      pend_d         = upc_pkg::PendNone;
    end else if (pend_q == upc_pkg::PendPct && upc_pkg::is_hex(in_byte_i)) begin
      if (in_last_i) begin
        pkt_o.bytes[0] = upc_pkg::CharPct;
        pkt_o.bytes[1] = in_byte_i;
        pkt_o.count    = 2'd2;
      end else begin
        held_d = in_byte_i;
        pend_d = upc_pkg::PendDigit;
      end
    end else begin
      if (pend_q == upc_pkg::PendPct) begin
        pre_cnt = 2'd1;
      end else if (pend_q == upc_pkg::PendDigit) begin
        pre_cnt = 2'd2;
      end
      pkt_o.bytes[0] = (pre_cnt != 2'd0) ? upc_pkg::CharPct : fresh_byte;
      pkt_o.bytes[1] = (pre_cnt == 2'd2) ? held_q : fresh_byte;
      pkt_o.bytes[2] = fresh_byte;
      pkt_o.count    = pre_cnt + {1'b0, fresh_emit};
      pend_d         = fresh_pend;
    end
    if (in_last_i) begin
      pend_d = upc_pkg::PendNone;
      held_d = '0;
    end
  end

  assign push_o = in_fire_i && (pkt_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pend_q <= upc_pkg::PendNone;
      held_q <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_decode_mode_i;
      pend_q <= upc_pkg::PendNone;
      held_q <= '0;
    end else if (in_fire_i) begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

endmodule

[src/upc_queue.sv]
// Two-entry packet queue between the front end and the back end.
module upc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upc_pkg::pkt_t pkt_i,
  output logic          full_o,
  output logic          valid_o,
  output upc_pkg::pkt_t head_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = $clog2(upc_pkg::QDepth);
  localparam int unsigned CntW = $clog2(upc_pkg::QDepth + 1);

  upc_pkg::pkt_t        mem_q [upc_pkg::QDepth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(upc_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && valid_o)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i && valid_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

[src/upc_back.sv]
// Back end: serializes queued packets into single output bytes through an output register.
module upc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  upc_pkg::pkt_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic [1:0] idx_q;
  logic       load;
  logic       tail;

  assign load  = valid_i && (!out_valid_q || !out_stall_i);
  assign tail  = (idx_q == head_i.count - 2'd1);
  assign pop_o = load && tail;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= head_i.bytes[idx_q];
      out_last_q <= head_i.last && tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        idx_q <= tail ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
